// ===== rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types, codes and constants of the round robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int DATA_W        = 16;
    localparam int TIME_W        = 21;
    localparam int PIDX_W        = 4;

    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    localparam logic [DATA_W-1:0] QUANTUM_RST = 16'd4;

    // request opcodes
    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    // per-process state
    typedef enum logic [1:0] {
        PS_WAITING = 2'd0,
        PS_QUEUED  = 2'd1,
        PS_DONE    = 2'd2
    } proc_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADMIT1,
        S_IDLE_OUT,
        S_ADMIT2,
        S_POP,
        S_ITEM_RD,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_ADMIT3,
        S_PUSH,
        S_PROC_OUT,
        S_DONE_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic do_load;
        logic do_clear;
        logic scan_init;
        logic scan_run;
        logic pop;
        logic item_capture;
        logic calc1;
        logic calc2;
        logic calc3;
        logic push;
        logic emit_idle;
        logic emit_proc;
        logic emit_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic none_left;
        logic scan_done;
        logic ring_empty;
        logic gap_found;
        logic calc_fin;
    } ctrl_sts_t;

    typedef struct packed {
        logic              slice_is_idle;
        logic [PIDX_W-1:0] process_index;
        logic [TIME_W-1:0] slice_start;
        logic [TIME_W-1:0] slice_end;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
        logic              last;
    } slice_rec_t;

endpackage

// ===== rtl/rrs_req_if.sv =====
// ----------------------------------------------------------------------------
// rrs_req_if
// Request channel: opcode plus process arrival and burst times.
// ----------------------------------------------------------------------------
interface rrs_req_if
    import rrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [DATA_W-1:0] arrival_time;
    logic [DATA_W-1:0] burst_time;

    modport source (output valid, output opcode, output arrival_time, output burst_time,
                    input ready);
    modport sink   (input valid, input opcode, input arrival_time, input burst_time,
                    output ready);
endinterface

// ===== rtl/rrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrs_rsp_if
// Result channel: one slice record per transfer.
// ----------------------------------------------------------------------------
interface rrs_rsp_if
    import rrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              slice_is_idle;
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic              last;

    modport source (output valid, output slice_is_idle, output process_index,
                    output slice_start, output slice_end, output finished,
                    output turnaround, output waiting, output all_done, output last,
                    input ready);
    modport sink   (input valid, input slice_is_idle, input process_index,
                    input slice_start, input slice_end, input finished,
                    input turnaround, input waiting, input all_done, input last,
                    output ready);
endinterface

// ===== rtl/rrs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rrs_cfg_if
// Configuration write channel for the time quantum.
// ----------------------------------------------------------------------------
interface rrs_cfg_if
    import rrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] quantum;

    modport source (output valid, output quantum, input ready);
    modport sink   (input valid, input quantum, output ready);
endinterface

// ===== rtl/round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_scheduler
// Load, clear and unused requests are taken in IDLE; a dispatch with nothing left goes to the done emit.
// A dispatch runs one admit scan for a finishing slice, two for a preempted slice and
// up to three with an idle gap (N = loaded processes): each admit scan reads the
// arrival table RAM one entry per cycle over all N entries.
// Results wait in an output register; a stalled result holds the sequencer at its next emit, taking no request.
// Reset clears process status, counters, ring pointers and time, and sets the
// quantum to 4; table contents are left as they are.
// ----------------------------------------------------------------------------
module round_robin_scheduler
    import rrs_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rrs_req_if.sink   req,
    rrs_rsp_if.source rsp,
    rrs_cfg_if.sink   cfg
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign req.ready = cmd.in_ready;

    rrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.opcode),
        .sts       (sts),
        .cmd       (cmd)
    );

    rrs_datapath #(.MAX_PROCS(MAX_PROCS)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .arrival_time (req.arrival_time),
        .burst_time   (req.burst_time),
        .rsp          (rsp),
        .cfg          (cfg)
    );

endmodule

// ===== rtl/rrs_ram.sv =====
// ----------------------------------------------------------------------------
// rrs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrs_ctrl
// Dispatch sequencer: admit scans, ring pop, slice arithmetic, result emits.
// ----------------------------------------------------------------------------
module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_op,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_op == OP_DISPATCH)
                begin
                    state_next = sts.none_left ? S_DONE_OUT : S_ADMIT1;
                end
            end
            S_ADMIT1:
            begin
                if (sts.scan_done)
                begin
                    if (!sts.ring_empty)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = sts.gap_found ? S_IDLE_OUT : S_DONE_OUT;
                    end
                end
            end
            S_IDLE_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_ADMIT2;
                end
            end
            S_ADMIT2:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:     state_next = S_ITEM_RD;
            S_ITEM_RD: state_next = S_CALC1;
            S_CALC1:   state_next = sts.calc_fin ? S_CALC2 : S_ADMIT3;
            S_CALC2:   state_next = S_CALC3;
            S_CALC3:   state_next = S_PROC_OUT;
            S_ADMIT3:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:    state_next = S_PROC_OUT;
            S_PROC_OUT, S_DONE_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.do_load   = req_valid && req_op == OP_LOAD;
                cmd.do_clear  = req_valid && req_op == OP_CLEAR;
                cmd.scan_init = req_valid && req_op == OP_DISPATCH && !sts.none_left;
            end
            S_ADMIT1, S_ADMIT2, S_ADMIT3:
            begin
                cmd.scan_run = 1'b1;
            end
            S_IDLE_OUT:
            begin
                // jump time to the next arrival and rescan
                cmd.emit_idle = sts.out_free;
                cmd.scan_init = sts.out_free;
            end
            S_POP:     cmd.pop = 1'b1;
            S_ITEM_RD: cmd.item_capture = 1'b1;
            S_CALC1:
            begin
                cmd.calc1     = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_CALC2:   cmd.calc2 = 1'b1;
            S_CALC3:   cmd.calc3 = 1'b1;
            S_PUSH:    cmd.push = 1'b1;
            S_PROC_OUT: cmd.emit_proc = sts.out_free;
            S_DONE_OUT: cmd.emit_done = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== rtl/rrs_datapath.sv =====
// ----------------------------------------------------------------------------
// rrs_datapath
// Process tables, ready ring, time keeping, slice arithmetic, result register.
// ----------------------------------------------------------------------------
module rrs_datapath
    import rrs_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output ctrl_sts_t         sts,
    input  logic [DATA_W-1:0] arrival_time,
    input  logic [DATA_W-1:0] burst_time,
    rrs_rsp_if.source         rsp,
    rrs_cfg_if.sink           cfg
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam logic [CNT_W-1:0] PROCS_C  = CNT_W'(MAX_PROCS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

    // control state
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  fin_cnt_reg,   fin_cnt_next;
    logic [IDX_W-1:0]  head_reg,      head_next;
    logic [IDX_W-1:0]  tail_reg,      tail_next;
    logic [CNT_W-1:0]  fill_reg,      fill_next;
    logic [TIME_W-1:0] time_reg,      time_next;
    logic [DATA_W-1:0] quantum_reg,   quantum_next;
    logic [CNT_W-1:0]  scan_idx_reg,  scan_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic              gap_any_reg,   gap_any_next;
    logic              out_valid_reg, out_valid_next;
    proc_state_t       status_reg [MAX_PROCS];
    proc_state_t       status_next [MAX_PROCS];

    // payload
    logic [IDX_W-1:0]  chk_idx_reg,   chk_idx_next;
    logic [DATA_W-1:0] gap_end_reg,   gap_end_next;
    logic [IDX_W-1:0]  item_reg,      item_next;
    logic [DATA_W-1:0] arr_reg,       arr_next;
    logic [DATA_W-1:0] burst_reg,     burst_next;
    logic [TIME_W-1:0] start_reg,     start_next;
    logic [TIME_W-1:0] end_reg,       end_next;
    logic              fin_reg,       fin_next;
    logic [TIME_W-1:0] ta_reg,        ta_next;
    logic [TIME_W-1:0] wt_reg,        wt_next;
    slice_rec_t        out_rec_reg,   out_rec_next;

    // memories
    logic              tbl_we, rem_we, ring_we;
    logic [IDX_W-1:0]  tbl_waddr, arr_raddr;
    logic [DATA_W-1:0] rem_wdata;
    logic [IDX_W-1:0]  ring_wdata;
    logic [DATA_W-1:0] arr_rdata, burst_rdata, rem_rdata;
    logic [IDX_W-1:0]  ring_rdata;

    // combinational helpers
    logic              issue;
    logic              load_ok;
    logic [DATA_W-1:0] q_eff;
    logic              calc_fin;
    logic [DATA_W-1:0] step;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] slice_end_c;
    logic [TIME_W-1:0] arr_ext;
    logic [TIME_W-1:0] burst_ext;
    logic              out_free;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        return (v == LAST_IDX) ? '0 : v + 1'b1;
    endfunction

    assign issue     = cmd.scan_run && (scan_idx_reg < count_reg);
    assign load_ok   = cmd.do_load && (count_reg < PROCS_C);
    assign q_eff     = (quantum_reg == '0) ? DATA_W'(1) : quantum_reg;
    assign calc_fin  = rem_rdata <= q_eff;
    assign step      = calc_fin ? rem_rdata : q_eff;
    assign sum       = {1'b0, time_reg} + (TIME_W + 1)'(step);
    assign slice_end_c = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    assign arr_ext   = TIME_W'(arr_reg);
    assign burst_ext = TIME_W'(burst_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign tbl_we    = load_ok;
    assign rem_we    = load_ok || (cmd.calc1 && !calc_fin);
    assign tbl_waddr = cmd.do_load ? count_reg[IDX_W-1:0] : item_reg;
    assign rem_wdata = cmd.do_load ? burst_time : rem_rdata - q_eff;
    assign arr_raddr = cmd.scan_run ? scan_idx_reg[IDX_W-1:0] : ring_rdata;

    always_comb
    begin
        count_next     = count_reg;
        fin_cnt_next   = fin_cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        time_next      = time_reg;
        quantum_next   = quantum_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        gap_any_next   = gap_any_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        chk_idx_next   = chk_idx_reg;
        gap_end_next   = gap_end_reg;
        item_next      = item_reg;
        arr_next       = arr_reg;
        burst_next     = burst_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        fin_next       = fin_reg;
        ta_next        = ta_reg;
        wt_next        = wt_reg;
        out_rec_next   = out_rec_reg;
        ring_we        = 1'b0;
        ring_wdata     = chk_idx_reg;

        if (cfg.valid)
        begin
            quantum_next = cfg.quantum;
        end

        // admit scan: address stage, then check stage in the following cycle
        if (cmd.scan_init)
        begin
            scan_idx_next  = '0;
            chk_valid_next = 1'b0;
            gap_any_next   = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            scan_idx_next  = issue ? scan_idx_reg + 1'b1 : scan_idx_reg;
            chk_valid_next = issue;
            chk_idx_next   = scan_idx_reg[IDX_W-1:0];
        end

        if (cmd.scan_run && chk_valid_reg && status_reg[chk_idx_reg] == PS_WAITING)
        begin
            if (TIME_W'(arr_rdata) <= time_reg)
            begin
                status_next[chk_idx_reg] = PS_QUEUED;
                ring_we = fill_reg < PROCS_C;
            end
            else if (!gap_any_reg || arr_rdata < gap_end_reg)
            begin
                // track earliest pending arrival for an idle gap
                gap_any_next = 1'b1;
                gap_end_next = arr_rdata;
            end
        end

        if (cmd.push)
        begin
            ring_wdata = item_reg;
            ring_we    = fill_reg < PROCS_C;
        end

        if (ring_we)
        begin
            tail_next = wrap_inc(tail_reg);
            fill_next = fill_reg + 1'b1;
        end

        if (cmd.pop)
        begin
            head_next = wrap_inc(head_reg);
            fill_next = fill_reg - 1'b1;
        end

        if (load_ok)
        begin
            status_next[count_reg[IDX_W-1:0]] = PS_WAITING;
            count_next = count_reg + 1'b1;
        end

        if (cmd.item_capture)
        begin
            item_next = ring_rdata;
        end

        if (cmd.calc1)
        begin
            arr_next   = arr_rdata;
            burst_next = burst_rdata;
            start_next = time_reg;
            end_next   = slice_end_c;
            fin_next   = calc_fin;
            ta_next    = '0;
            wt_next    = '0;
            time_next  = slice_end_c;
            if (calc_fin)
            begin
                status_next[item_reg] = PS_DONE;
                fin_cnt_next = fin_cnt_reg + 1'b1;
            end
        end

        if (cmd.calc2)
        begin
            ta_next = (end_reg >= arr_ext) ? end_reg - arr_ext : '0;
        end

        if (cmd.calc3)
        begin
            wt_next = (ta_reg >= burst_ext) ? ta_reg - burst_ext : '0;
        end

        // result register: hold until taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_idle)
        begin
            out_valid_next             = 1'b1;
            out_rec_next               = '0;
            out_rec_next.slice_is_idle = 1'b1;
            out_rec_next.slice_start   = time_reg;
            out_rec_next.slice_end     = TIME_W'(gap_end_reg);
            time_next                  = TIME_W'(gap_end_reg);
        end

        if (cmd.emit_proc)
        begin
            out_valid_next             = 1'b1;
            out_rec_next               = '0;
            out_rec_next.process_index = PIDX_W'(item_reg);
            out_rec_next.slice_start   = start_reg;
            out_rec_next.slice_end     = end_reg;
            out_rec_next.finished      = fin_reg;
            out_rec_next.turnaround    = ta_reg;
            out_rec_next.waiting       = wt_reg;
            out_rec_next.last          = 1'b1;
        end

        if (cmd.emit_done)
        begin
            out_valid_next        = 1'b1;
            out_rec_next          = '0;
            out_rec_next.all_done = 1'b1;
            out_rec_next.last     = 1'b1;
        end

        if (cmd.do_clear)
        begin
            count_next   = '0;
            fin_cnt_next = '0;
            head_next    = '0;
            tail_next    = '0;
            fill_next    = '0;
            time_next    = '0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                status_next[i] = PS_WAITING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fin_cnt_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            time_reg      <= '0;
            quantum_reg   <= QUANTUM_RST;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            gap_any_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                status_reg[i] <= PS_WAITING;
            end
        end
        else
        begin
            count_reg     <= count_next;
            fin_cnt_reg   <= fin_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            time_reg      <= time_next;
            quantum_reg   <= quantum_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            gap_any_reg   <= gap_any_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        gap_end_reg <= gap_end_next;
        item_reg    <= item_next;
        arr_reg     <= arr_next;
        burst_reg   <= burst_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        fin_reg     <= fin_next;
        ta_reg      <= ta_next;
        wt_reg      <= wt_next;
        out_rec_reg <= out_rec_next;
    end

    rrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_arrival_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (arrival_time),
        .raddr (arr_raddr),
        .rdata (arr_rdata)
    );

    rrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_burst_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (burst_time),
        .raddr (ring_rdata),
        .rdata (burst_rdata)
    );

    rrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_remain_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (tbl_waddr),
        .wdata (rem_wdata),
        .raddr (ring_rdata),
        .rdata (rem_rdata)
    );

    rrs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    assign sts.out_free   = out_free;
    assign sts.none_left  = fin_cnt_reg >= count_reg;
    assign sts.scan_done  = cmd.scan_run && !issue && !chk_valid_reg;
    assign sts.ring_empty = fill_reg == '0;
    assign sts.gap_found  = gap_any_reg;
    assign sts.calc_fin   = calc_fin;

    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.slice_is_idle = out_rec_reg.slice_is_idle;
    assign rsp.process_index = out_rec_reg.process_index;
    assign rsp.slice_start   = out_rec_reg.slice_start;
    assign rsp.slice_end     = out_rec_reg.slice_end;
    assign rsp.finished      = out_rec_reg.finished;
    assign rsp.turnaround    = out_rec_reg.turnaround;
    assign rsp.waiting       = out_rec_reg.waiting;
    assign rsp.all_done      = out_rec_reg.all_done;
    assign rsp.last          = out_rec_reg.last;

endmodule
